>>> hdl/bcs_pkg.sv
// Shared types, fixed-point constants and command codes for the battery charge step.
// No dependencies; compiled first.
package bcs_pkg;

  localparam int FRAC_BITS = 16;

  // Fixed-point constants, rounded to nearest
  localparam logic signed [31:0] E0_FX =
    32'((124659 * (longint'(1) << FRAC_BITS) + 5000) / 10000);
  localparam logic signed [31:0] R_FX =
    32'((25 * (longint'(1) << FRAC_BITS) + 500) / 1000);
  localparam logic signed [31:0] K_FX =
    32'((47 * (longint'(1) << FRAC_BITS) + 500) / 1000);
  localparam logic signed [31:0] A_FX =
    32'((83 * (longint'(1) << FRAC_BITS) + 50) / 100);
  localparam logic [21:0] V_MAX = 22'(32 << FRAC_BITS);
  localparam logic [21:0] V_RESET = 22'(12 << FRAC_BITS);

  // Register reset values
  localparam logic [25:0] CAP_RESET = 26'd458752;
  localparam logic [16:0] DT_RESET = 17'd16384;
  localparam logic [21:0] CUT_HI_RESET = 22'd878182;
  localparam logic [21:0] TAPER_RESET = 22'd865075;
  localparam logic [21:0] CUT_LO_RESET = 22'd681574;

  // Register indexes
  localparam logic [2:0] CFG_CAP = 3'd0;
  localparam logic [2:0] CFG_DT = 3'd1;
  localparam logic [2:0] CFG_CUT_HI = 3'd2;
  localparam logic [2:0] CFG_TAPER = 3'd3;
  localparam logic [2:0] CFG_CUT_LO = 3'd4;

  // Divider iteration counts
  localparam logic [4:0] DIV1_STEPS = 5'd31;
  localparam logic [4:0] DIV2_STEPS = 5'd23;

  // Datapath operations
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_G1 = 4'd2;
  localparam logic [3:0] OP_G2 = 4'd3;
  localparam logic [3:0] OP_GD = 4'd4;
  localparam logic [3:0] OP_EZ = 4'd5;
  localparam logic [3:0] OP_DS1 = 4'd6;
  localparam logic [3:0] OP_DIV = 4'd7;
  localparam logic [3:0] OP_CF = 4'd8;
  localparam logic [3:0] OP_CS = 4'd9;
  localparam logic [3:0] OP_VT = 4'd10;
  localparam logic [3:0] OP_CT = 4'd11;
  localparam logic [3:0] OP_CH = 4'd12;
  localparam logic [3:0] OP_PM = 4'd13;
  localparam logic [3:0] OP_DS2 = 4'd14;
  localparam logic [3:0] OP_WB = 4'd15;

  typedef struct packed {
    logic [3:0] op;
  } bcs_cmd_t;

  typedef struct packed {
    logic coef_sat;
  } bcs_stat_t;

endpackage

>>> hdl/bcs_stream_if.sv
// Valid/ready channels for the battery charge step: input word and result word.
// Depends on nothing.
interface bcs_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] load_current;
  logic [20:0] pv_current;
  modport source (output valid, load_current, pv_current, input ready);
  modport sink (input valid, load_current, pv_current, output ready);
endinterface

interface bcs_out_if;
  logic        valid;
  logic        ready;
  logic [21:0] battery_voltage;
  logic [25:0] stored_charge;
  logic [22:0] charge_percent;
  logic [20:0] load_served;
  modport source (output valid, battery_voltage, stored_charge, charge_percent, load_served,
                  input ready);
  modport sink (input valid, battery_voltage, stored_charge, charge_percent, load_served,
                output ready);
endinterface

>>> hdl/bcs_datapath.sv
// Datapath of the battery charge step: registers, shared multiplier, restoring divider.
// Depends on bcs_pkg; driven by bcs_ctrl through bcs_cmd_t.
module bcs_datapath import bcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data,
  input  logic [20:0] in_load_current,
  input  logic [20:0] in_pv_current,
  input  bcs_cmd_t    cmd,
  output bcs_stat_t   stat,
  output logic [21:0] out_battery_voltage,
  output logic [25:0] out_stored_charge,
  output logic [22:0] out_charge_percent,
  output logic [20:0] out_load_served
);

  logic [25:0] cap_r;
  logic [16:0] dt_r;
  logic [21:0] cut_hi_r, taper_r, cut_lo_r;
  logic [21:0] prev_v_r;
  logic signed [31:0] ezv_r;
  logic [25:0] charge_r;

  logic [20:0] load_r, pv_r;
  logic signed [23:0] cur_r;
  logic signed [63:0] prod_r;
  logic signed [47:0] cs_r;
  logic [21:0] v_r;
  logic [25:0] c_r;
  logic [25:0] rem_r, dvs_r;
  logic [48:0] dq_r;
  logic sat_r;
  logic [21:0] ov_r;
  logic [25:0] oc_r;
  logic [22:0] op_r;
  logic [20:0] ol_r;

  function automatic logic signed [22:0] ctrl_cur(input logic [21:0] v,
      input logic [20:0] ld, input logic [20:0] pv, input logic [21:0] lo,
      input logic [21:0] hi, input logic [21:0] tp);
    logic signed [22:0] r;
    if (v <= lo) begin
      r = $signed({2'b0, pv});
    end else if (v >= hi) begin
      r = -$signed({2'b0, ld});
    end else if (v > tp) begin
      r = -$signed({2'b0, ld});
    end else begin
      r = $signed({2'b0, pv}) - $signed({2'b0, ld});
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    logic signed [31:0] r;
    if (x > 50'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -50'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  logic signed [22:0] ctrl_in, ctrl_v;
  logic signed [23:0] cur_abs;
  logic [22:0] mag;
  logic signed [63:0] prod_sh;
  logic signed [31:0] g_sat, diff, target, coef;
  logic signed [49:0] ezv_sum, v_calc;
  logic [21:0] kq, v_clamp;
  logic [25:0] divisor1, divisor2, rem_n, c_clamp;
  logic sat1, ge;
  logic [26:0] trial;
  logic signed [27:0] span, c_calc;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic mul_en;

  always_comb begin
    ctrl_in = ctrl_cur(prev_v_r, in_load_current, in_pv_current, cut_lo_r, cut_hi_r, taper_r);
    ctrl_v = ctrl_cur(v_r, load_r, pv_r, cut_lo_r, cut_hi_r, taper_r);
    cur_abs = cur_r[23] ? -cur_r : cur_r;
    mag = cur_abs[22:0];
    prod_sh = prod_r >>> FRAC_BITS;
    g_sat = sat32(50'(prod_sh));
    target = cur_r[23] ? -A_FX : 32'sd0;
    diff = sat32(50'(target) - 50'(ezv_r));
    ezv_sum = 50'(ezv_r) + 50'(prod_sh);
    kq = prod_r[37:16];
    divisor1 = (charge_r == 26'd0) ? 26'd1 : charge_r;
    divisor2 = (cap_r == 26'd0) ? 26'd1 : cap_r;
    sat1 = {19'b0, kq[21:15]} >= divisor1;
    trial = {rem_r, dq_r[48]};
    ge = trial >= {1'b0, dvs_r};
    rem_n = ge ? 26'(trial - {1'b0, dvs_r}) : trial[25:0];
    coef = sat_r ? 32'sh7FFF_FFFF : $signed({1'b0, dq_r[30:0]});
    span = $signed({2'b0, cap_r}) - $signed({2'b0, charge_r}) + 28'(cur_r);
    v_calc = 50'(E0_FX) - 50'(prod_sh) - 50'(cs_r) - 50'(ezv_r);
    if (v_calc < 50'sd0) begin
      v_clamp = 22'd0;
    end else if (v_calc > $signed({28'b0, V_MAX})) begin
      v_clamp = V_MAX;
    end else begin
      v_clamp = v_calc[21:0];
    end
    c_calc = $signed({2'b0, charge_r}) + 28'(prod_sh);
    if (c_calc > $signed({2'b0, cap_r})) begin
      c_clamp = cap_r;
    end else if (c_calc < 28'sd0) begin
      c_clamp = 26'd0;
    end else begin
      c_clamp = c_calc[25:0];
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_G1: begin
        mul_a = $signed({10'b0, mag});
        mul_b = 33'sd125;
      end
      OP_G2: begin
        mul_a = $signed({3'b0, prod_r[29:0]});
        mul_b = $signed({16'b0, dt_r});
      end
      OP_GD: begin
        mul_a = 33'(g_sat);
        mul_b = 33'(diff);
      end
      OP_EZ: begin
        mul_a = $signed({7'b0, cap_r});
        mul_b = 33'(K_FX);
      end
      OP_CF: begin
        mul_a = 33'(coef);
        mul_b = 33'(span);
      end
      OP_CS: begin
        mul_a = 33'(cur_r);
        mul_b = 33'(R_FX);
      end
      OP_CT: begin
        mul_a = 33'(ctrl_v);
        mul_b = $signed({16'b0, dt_r});
      end
      OP_PM: begin
        mul_a = $signed({7'b0, c_r});
        mul_b = 33'sd100;
      end
      default: mul_en = 1'b0;
    endcase
    mul_p = mul_a * mul_b;
  end

  assign stat.coef_sat = sat1;

  // Configuration and battery state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      dt_r <= DT_RESET;
      cut_hi_r <= CUT_HI_RESET;
      taper_r <= TAPER_RESET;
      cut_lo_r <= CUT_LO_RESET;
      prev_v_r <= V_RESET;
      ezv_r <= 32'sd0;
      charge_r <= 26'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CAP: cap_r <= cfg_data;
          CFG_DT: dt_r <= cfg_data[16:0];
          CFG_CUT_HI: cut_hi_r <= cfg_data[21:0];
          CFG_TAPER: taper_r <= cfg_data[21:0];
          CFG_CUT_LO: cut_lo_r <= cfg_data[21:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_EZ) begin
        ezv_r <= sat32(ezv_sum);
      end
      if (cmd.op == OP_WB) begin
        prev_v_r <= v_r;
        charge_r <= c_r;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= 64'(mul_p);
    end
    case (cmd.op)
      OP_LOAD: begin
        load_r <= in_load_current;
        pv_r <= in_pv_current;
        cur_r <= $signed({3'b0, in_load_current}) - 24'(ctrl_in);
      end
      OP_DS1: begin
        dvs_r <= divisor1;
        rem_r <= {19'b0, kq[21:15]};
        dq_r <= {kq[14:0], 34'b0};
        sat_r <= sat1;
      end
      OP_DIV: begin
        rem_r <= rem_n;
        dq_r <= {dq_r[47:0], ge};
      end
      OP_CS: cs_r <= 48'(prod_sh);
      OP_VT: v_r <= v_clamp;
      OP_CH: c_r <= c_clamp;
      OP_DS2: begin
        dvs_r <= divisor2;
        rem_r <= prod_r[32:7];
        dq_r <= {prod_r[6:0], 42'b0};
      end
      OP_WB: begin
        ov_r <= v_r;
        oc_r <= c_r;
        op_r <= dq_r[22:0];
        ol_r <= (v_r > cut_lo_r) ? load_r : 21'd0;
      end
      default: ;
    endcase
  end

  assign out_battery_voltage = ov_r;
  assign out_stored_charge = oc_r;
  assign out_charge_percent = op_r;
  assign out_load_served = ol_r;

  a_charge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_CH |=> c_r <= cap_r)
    else $error("charge above capacity after clamp");
  a_volt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_VT |=> v_r <= V_MAX)
    else $error("voltage above 32 V after clamp");

endmodule

>>> hdl/bcs_ctrl.sv
// Sequencer of the battery charge step: step states, divider count, handshakes.
// Depends on bcs_pkg; commands bcs_datapath.
module bcs_ctrl import bcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  bcs_stat_t stat,
  output bcs_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_G1 = 4'd1;
  localparam logic [3:0] ST_G2 = 4'd2;
  localparam logic [3:0] ST_GD = 4'd3;
  localparam logic [3:0] ST_EZ = 4'd4;
  localparam logic [3:0] ST_DS1 = 4'd5;
  localparam logic [3:0] ST_DV1 = 4'd6;
  localparam logic [3:0] ST_CF = 4'd7;
  localparam logic [3:0] ST_CS = 4'd8;
  localparam logic [3:0] ST_VT = 4'd9;
  localparam logic [3:0] ST_CT = 4'd10;
  localparam logic [3:0] ST_CH = 4'd11;
  localparam logic [3:0] ST_PM = 4'd12;
  localparam logic [3:0] ST_DS2 = 4'd13;
  localparam logic [3:0] ST_DV2 = 4'd14;
  localparam logic [3:0] ST_WB = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_acc;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.op = OP_LOAD;
          state_nxt = ST_G1;
        end
      end
      ST_G1: begin
        cmd.op = OP_G1;
        state_nxt = ST_G2;
      end
      ST_G2: begin
        cmd.op = OP_G2;
        state_nxt = ST_GD;
      end
      ST_GD: begin
        cmd.op = OP_GD;
        state_nxt = ST_EZ;
      end
      ST_EZ: begin
        cmd.op = OP_EZ;
        state_nxt = ST_DS1;
      end
      ST_DS1: begin
        cmd.op = OP_DS1;
        cnt_nxt = DIV1_STEPS;
        // skip the divide when the quotient saturates anyway
        state_nxt = stat.coef_sat ? ST_CF : ST_DV1;
      end
      ST_DV1: begin
        cmd.op = OP_DIV;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          state_nxt = ST_CF;
        end
      end
      ST_CF: begin
        cmd.op = OP_CF;
        state_nxt = ST_CS;
      end
      ST_CS: begin
        cmd.op = OP_CS;
        state_nxt = ST_VT;
      end
      ST_VT: begin
        cmd.op = OP_VT;
        state_nxt = ST_CT;
      end
      ST_CT: begin
        cmd.op = OP_CT;
        state_nxt = ST_CH;
      end
      ST_CH: begin
        cmd.op = OP_CH;
        state_nxt = ST_PM;
      end
      ST_PM: begin
        cmd.op = OP_PM;
        state_nxt = ST_DS2;
      end
      ST_DS2: begin
        cmd.op = OP_DS2;
        cnt_nxt = DIV2_STEPS;
        state_nxt = ST_DV2;
      end
      ST_DV2: begin
        cmd.op = OP_DIV;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.op = OP_WB;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_G1)
    else $error("accepted word did not start the sequence");
  a_div_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DV1 || state_r == ST_DV2) |-> cnt_r != 5'd0)
    else $error("divider running with empty count");
  a_wb_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB && out_valid_r && !out_ready) |=> state_r == ST_WB)
    else $error("write-back overran a pending word");
  a_valid_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_WB)
    else $error("result raised outside write-back");

endmodule

>>> hdl/battery_charge_step.sv
// Top level of the battery charge step: channels, configuration port, sequencer, datapath.
// Depends on bcs_pkg, bcs_stream_if, bcs_ctrl and bcs_datapath.
//
// One word in is one simulation tick of a lead-acid battery behind a solar charge
// controller, signed Q16.16 inside. An input word (load and PV current) is taken only
// while no tick is in progress; it yields exactly one result word (terminal voltage,
// stored charge, state of charge, load served). A sequencer walks one shared 33x33
// multiplier through eight products and runs a one-bit-per-cycle restoring divider
// twice, 31 steps for the coefficient 0.047*Q/charge and 23 steps for the percentage;
// the first run is skipped when that coefficient saturates. The next word is accepted
// as soon as the result sits in the output register, even while that result waits to
// be taken. Registers are written through cfg_we/cfg_index/cfg_data while the block is
// idle, a rule for the user that the block does not enforce; indexes 0..4 are capacity,
// tick length, high cutoff, taper level and low cutoff; other indexes are ignored.
module battery_charge_step import bcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bcs_in_if.sink      in_if,
  bcs_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data
);

  bcs_cmd_t  cmd;
  bcs_stat_t stat;

  // sequencer: owns handshakes and the divider count
  bcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: battery state, registers and arithmetic
  bcs_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_load_current     (in_if.load_current),
    .in_pv_current       (in_if.pv_current),
    .cmd                 (cmd),
    .stat                (stat),
    .out_battery_voltage (out_if.battery_voltage),
    .out_stored_charge   (out_if.stored_charge),
    .out_charge_percent  (out_if.charge_percent),
    .out_load_served     (out_if.load_served)
  );

endmodule
